@@ rtl/assert_macros.svh @@
// assertion macros shared by the parser rtl
// each use expects clk and arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define MTRP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define MTRP_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/mtrp_pkg.sv @@
// shared types and codes of the modbus tcp response parser
// no dependencies
package mtrp_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int POS_W = 17;

	// input action codes
	localparam logic [1:0] ACT_ARM     = 2'd0;
	localparam logic [1:0] ACT_BYTE    = 2'd1;
	localparam logic [1:0] ACT_TIMEOUT = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_COIL   = 2'd0;
	localparam logic [1:0] KIND_REG    = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// final status codes
	localparam logic [3:0] ST_OK          = 4'd0;
	localparam logic [3:0] ST_TID         = 4'd1;
	localparam logic [3:0] ST_PROTOCOL    = 4'd2;
	localparam logic [3:0] ST_LENGTH      = 4'd3;
	localparam logic [3:0] ST_EXCEPTION   = 4'd4;
	localparam logic [3:0] ST_FC          = 4'd5;
	localparam logic [3:0] ST_SHORT_DATA  = 4'd6;
	localparam logic [3:0] ST_INCOMPLETE  = 4'd7;
	localparam logic [3:0] ST_WRITE_SHORT = 4'd8;
	localparam logic [3:0] ST_TRUNCATED   = 4'd9;
	localparam logic [3:0] ST_TIMEOUT     = 4'd10;
	localparam logic [3:0] ST_TOO_SHORT   = 4'd11;

	// function codes of interest
	localparam logic [6:0] FC_READ_COILS  = 7'd1;
	localparam logic [6:0] FC_READ_INPUTS = 7'd2;
	localparam logic [6:0] FC_READ_HOLD   = 7'd3;
	localparam logic [6:0] FC_READ_INREG  = 7'd4;

	// byte positions in the frame
	localparam logic [POS_W-1:0] POS_TID_LO   = 17'd1;
	localparam logic [POS_W-1:0] POS_PROTO_HI = 17'd2;
	localparam logic [POS_W-1:0] POS_PROTO_LO = 17'd3;
	localparam logic [POS_W-1:0] POS_LEN_HI   = 17'd4;
	localparam logic [POS_W-1:0] POS_LEN_LO   = 17'd5;
	localparam logic [POS_W-1:0] POS_FC       = 17'd7;
	localparam logic [POS_W-1:0] POS_COUNT    = 17'd8;
	localparam logic [POS_W-1:0] POS_DATA     = 17'd9;
	localparam logic [POS_W-1:0] MBAP_BYTES   = 17'd6;
	localparam logic [POS_W-1:0] WRITE_MIN    = 17'd12;

	// one queue entry: an optional data result followed by an optional status
	typedef struct packed {
		logic        has_data;
		logic [1:0]  data_kind;
		logic [15:0] value;
		logic [3:0]  bits_valid;
		logic        has_status;
		logic [3:0]  status;
		logic [7:0]  exception_code;
	} mtrp_entry_t;

endpackage

@@ rtl/mtrp_queue.sv @@
// small result queue between the byte front end and the output back end
// depends on mtrp_pkg
module mtrp_queue import mtrp_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  mtrp_entry_t push_entry,
	output logic        full,
	input  logic        pop,
	output mtrp_entry_t head,
	output logic        empty
);
	`include "assert_macros.svh"

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mtrp_entry_t             slot_q [DEPTH];
	logic        [PTR_W-1:0] wr_ptr_q;
	logic        [PTR_W-1:0] rd_ptr_q;
	logic        [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`MTRP_ASSERT_IMPL(a_no_push_full, push, !full, "queue written while full")
	`MTRP_ASSERT_IMPL(a_no_pop_empty, pop, !empty, "queue read while empty")

endmodule

@@ rtl/mtrp_front.sv @@
// front end: accepts items, tracks the frame and decides the results of each beat
// depends on mtrp_pkg
module mtrp_front import mtrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // data_byte, expected_tid, expected_fc, item_count, zero pad
	input  logic [1:0]  s_tuser,   // action
	input  logic        q_full,
	output logic        q_push,
	output mtrp_entry_t q_entry
);

	typedef enum logic [1:0] {
		PH_IDLE   = 2'b01,
		PH_ACTIVE = 2'b10
	} phase_t;

	phase_t             phase_q, phase_n;
	logic [POS_W-1:0]   pos_q, pos_n;
	logic [POS_W-1:0]   flen_q, flen_n;
	logic [15:0]        tid_q, tid_n;
	logic [6:0]         fcw_q, fcw_n;
	logic [15:0]        coils_q, coils_n;
	logic [7:0]         hhb_q, hhb_n;
	logic [7:0]         dbc_q, dbc_n;
	logic [7:0]         fcr_q, fcr_n;
	logic [7:0]         exc_q, exc_n;

	logic               accept;
	logic [7:0]         b;
	logic [15:0]        word;
	logic [POS_W-1:0]   d;
	logic [3:0]         n_coils;
	logic [7:0]         mask;
	logic               fc_ok;
	logic               is_bits;
	logic               is_regs;
	mtrp_entry_t        ent;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign b        = s_tdata[7:0];
	assign word     = {hhb_q, b};
	assign d        = pos_q - POS_DATA;
	assign fc_ok    = !fcr_q[7] && (fcr_q == {1'b0, fcw_q});
	assign is_bits  = (fcw_q == FC_READ_COILS) || (fcw_q == FC_READ_INPUTS);
	assign is_regs  = (fcw_q == FC_READ_HOLD) || (fcw_q == FC_READ_INREG);
	assign n_coils  = (coils_q < 16'd8) ? coils_q[3:0] : 4'd8;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			mask[i] = (4'(i) < n_coils);
		end
	end

	always_comb begin
		phase_n = phase_q;
		pos_n   = pos_q;
		flen_n  = flen_q;
		tid_n   = tid_q;
		fcw_n   = fcw_q;
		coils_n = coils_q;
		hhb_n   = hhb_q;
		dbc_n   = dbc_q;
		fcr_n   = fcr_q;
		exc_n   = exc_q;
		ent     = '0;
		if (accept) begin
			unique case (s_tuser)
				ACT_ARM: begin
					phase_n = PH_ACTIVE;
					pos_n   = '0;
					flen_n  = '0;
					tid_n   = s_tdata[23:8];
					fcw_n   = s_tdata[30:24];
					coils_n = s_tdata[46:31];
					hhb_n   = '0;
					dbc_n   = '0;
					fcr_n   = '0;
					exc_n   = '0;
				end
				ACT_TIMEOUT: begin
					if (phase_q == PH_ACTIVE) begin
						phase_n        = PH_IDLE;
						ent.has_status = 1'b1;
						if (pos_q == '0) begin
							ent.status = ST_TIMEOUT;
						end else if (pos_q < POS_FC) begin
							ent.status = ST_TOO_SHORT;
						end else begin
							ent.status = ST_TRUNCATED;
						end
					end
				end
				ACT_BYTE: begin
					if (phase_q == PH_ACTIVE) begin
						pos_n = pos_q + 1'b1;
						if (pos_q == '0 || pos_q == POS_PROTO_HI || pos_q == POS_LEN_HI) begin
							hhb_n = b;
						end else if (pos_q == POS_TID_LO) begin
							if (word != tid_q) begin
								phase_n        = PH_IDLE;
								ent.has_status = 1'b1;
								ent.status     = ST_TID;
							end
						end else if (pos_q == POS_PROTO_LO) begin
							if (word != '0) begin
								phase_n        = PH_IDLE;
								ent.has_status = 1'b1;
								ent.status     = ST_PROTOCOL;
							end
						end else if (pos_q == POS_LEN_LO) begin
							if (word < 16'd2) begin
								phase_n        = PH_IDLE;
								ent.has_status = 1'b1;
								ent.status     = ST_LENGTH;
							end else begin
								flen_n = MBAP_BYTES + POS_W'(word);
							end
						end else begin
							if (pos_q == POS_FC) begin
								fcr_n = b;
							end else if (pos_q == POS_COUNT) begin
								if (fcr_q[7]) begin
									exc_n = b;
								end else begin
									dbc_n = b;
								end
							end else if (pos_q >= POS_DATA && fc_ok && d < POS_W'(dbc_q)) begin
								if (is_bits) begin
									if (coils_q != '0) begin
										ent.has_data   = 1'b1;
										ent.data_kind  = KIND_COIL;
										ent.value      = {8'h00, b & mask};
										ent.bits_valid = n_coils;
										coils_n        = coils_q - 16'(n_coils);
									end
								end else if (is_regs) begin
									if (!d[0]) begin
										hhb_n = b;
									end else if (d < POS_W'({dbc_q[7:1], 1'b0})) begin
										ent.has_data  = 1'b1;
										ent.data_kind = KIND_REG;
										ent.value     = word;
									end
								end
							end
							// frame end check uses the values this beat just stored
							if (pos_q >= POS_FC && pos_n == flen_q) begin
								phase_n        = PH_IDLE;
								ent.has_status = 1'b1;
								if (fcr_n[7]) begin
									ent.status         = ST_EXCEPTION;
									ent.exception_code = exc_n;
								end else if (fcr_n != {1'b0, fcw_q}) begin
									ent.status = ST_FC;
								end else if (is_bits || is_regs) begin
									if (flen_q < POS_DATA) begin
										ent.status = ST_SHORT_DATA;
									end else if (flen_q < POS_DATA + POS_W'(dbc_n)) begin
										ent.status = ST_INCOMPLETE;
									end else begin
										ent.status = ST_OK;
									end
								end else begin
									ent.status = (flen_q < WRITE_MIN) ? ST_WRITE_SHORT : ST_OK;
								end
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign q_push  = ent.has_data || ent.has_status;
	assign q_entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= '0;
			flen_q  <= '0;
			tid_q   <= '0;
			fcw_q   <= '0;
			coils_q <= '0;
			hhb_q   <= '0;
			dbc_q   <= '0;
			fcr_q   <= '0;
			exc_q   <= '0;
		end else begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			flen_q  <= flen_n;
			tid_q   <= tid_n;
			fcw_q   <= fcw_n;
			coils_q <= coils_n;
			hhb_q   <= hhb_n;
			dbc_q   <= dbc_n;
			fcr_q   <= fcr_n;
			exc_q   <= exc_n;
		end
	end

endmodule

@@ rtl/mtrp_back.sv @@
// back end: drains queue entries into the output register, one result per beat
// depends on mtrp_pkg
module mtrp_back import mtrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  mtrp_entry_t head,
	input  logic        q_empty,
	output logic        q_pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // value, bits_valid, status, exception_code
	output logic [1:0]  m_tuser,   // result_kind
	output logic        m_tlast
);
	`include "assert_macros.svh"

	logic        m_tvalid_q;
	logic        sent_q;
	logic [1:0]  kind_q;
	logic [15:0] value_q;
	logic [3:0]  bits_q;
	logic [3:0]  status_q;
	logic [7:0]  exc_q;
	logic        last_q;
	logic        load;
	logic        send_data;

	assign load      = !q_empty && (!m_tvalid_q || m_tready);
	assign send_data = head.has_data && !sent_q;
	// an entry with data and status leaves over two beats
	assign q_pop     = load && (!send_data || !head.has_status);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			sent_q     <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
			sent_q     <= send_data && head.has_status;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (send_data) begin
				kind_q   <= head.data_kind;
				value_q  <= head.value;
				bits_q   <= head.bits_valid;
				status_q <= ST_OK;
				exc_q    <= '0;
				last_q   <= 1'b0;
			end else begin
				kind_q   <= KIND_STATUS;
				value_q  <= '0;
				bits_q   <= '0;
				status_q <= head.status;
				exc_q    <= head.exception_code;
				last_q   <= 1'b1;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {exc_q, status_q, bits_q, value_q};
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

	`MTRP_ASSERT_IMPL(a_sent_has_entry, sent_q, !q_empty && head.has_status,
		"status half of an entry missing")
	`MTRP_ASSERT_IMPL(a_last_is_status, m_tvalid_q, (last_q == (kind_q == KIND_STATUS)),
		"tlast disagrees with result kind")

endmodule

@@ rtl/modbus_tcp_response_parser_unit.sv @@
// Modbus TCP response parser: arm with the request, feed the response byte by byte
// (action in s_tuser), and read coil groups, register words and one final status
// per transaction. A new item is taken every cycle while the result queue has room;
// an item's results go through the result queue into the output register and leave
// one per cycle while the output is not stalled, so a byte that yields both a data
// result and the final status gives a data beat, then a status beat. The queue
// depth (QUEUE_DEPTH, default 4) sets how long input flows while output stalls.
// depends on mtrp_pkg, mtrp_front, mtrp_queue, mtrp_back
module modbus_tcp_response_parser_unit import mtrp_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // data_byte, expected_tid, expected_fc, item_count, zero pad
	input  logic [1:0]  s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // value, bits_valid, status, exception_code
	output logic [1:0]  m_tuser,   // result_kind
	output logic        m_tlast
);

	logic        q_push;
	logic        q_full;
	logic        q_pop;
	logic        q_empty;
	mtrp_entry_t q_entry;
	mtrp_entry_t q_head;

	mtrp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_entry)
	);

	mtrp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head       (q_head),
		.empty      (q_empty)
	);

	mtrp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

@@ tb/modbus_tcp_response_parser_check.sv @@
`timescale 1ns / 100ps
// result checker for the modbus tcp response parser: keeps its own copy of the parser
// state, predicts result beats from accepted input beats and compares the output channel
// depends on mtrp_pkg
module modbus_tcp_response_parser_check import mtrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,   // data_byte, expected_tid, expected_fc, item_count, zero pad
	input  logic [1:0]  s_tuser,   // action
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // value, bits_valid, status, exception_code
	input  logic [1:0]  m_tuser,   // result_kind
	input  logic        m_tlast,
	output int          errors,
	output int          pending,
	output int          coil_groups,
	output int          reg_words,
	output int          statuses,
	output logic [15:0] status_seen
);

	localparam logic [POS_W-1:0] POS_TID_HI = '0;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] value;
		logic [3:0]  bits;
		logic [3:0]  status;
		logic [7:0]  code;
		logic        last;
	} parse_result_t;

	parse_result_t parsed_results[$];

	// mirror of the parser state, reset values
	logic             armed = 1'b0;
	logic [POS_W-1:0] pos = '0;
	logic [POS_W-1:0] frame_end = '0;
	logic [15:0]      want_tid = '0;
	logic [6:0]       want_fc = '0;
	logic [15:0]      coils_left = '0;
	logic [7:0]       hi_byte = '0;
	logic [7:0]       byte_count = '0;
	logic [7:0]       got_fc = '0;
	logic [7:0]       exc_code = '0;

	int          n_errors = 0;
	int          n_pending = 0;
	int          n_coil = 0;
	int          n_reg = 0;
	int          n_status = 0;
	logic [15:0] seen = '0;

	assign errors      = n_errors;
	assign pending     = n_pending;
	assign coil_groups = n_coil;
	assign reg_words   = n_reg;
	assign statuses    = n_status;
	assign status_seen = seen;

	function automatic void push_result(logic [1:0] kind, logic [15:0] value, logic [3:0] bits,
			logic [3:0] status, logic [7:0] code);
		parsed_results.push_back('{kind, value, bits, status, code, kind == KIND_STATUS});
	endfunction

	function automatic void close_frame(logic [3:0] status, logic [7:0] code);
		push_result(KIND_STATUS, 16'h0000, 4'h0, status, code);
		armed = 1'b0;
	endfunction

	function automatic void end_of_frame();
		if (got_fc[7]) begin
			close_frame(ST_EXCEPTION, exc_code);
		end else if (got_fc != {1'b0, want_fc}) begin
			close_frame(ST_FC, 8'h00);
		end else if (want_fc >= FC_READ_COILS && want_fc <= FC_READ_INREG) begin
			if (frame_end < POS_DATA)
				close_frame(ST_SHORT_DATA, 8'h00);
			else if (frame_end < POS_DATA + byte_count)
				close_frame(ST_INCOMPLETE, 8'h00);
			else
				close_frame(ST_OK, 8'h00);
		end else begin
			close_frame(frame_end < WRITE_MIN ? ST_WRITE_SHORT : ST_OK, 8'h00);
		end
	endfunction

	function automatic void parse_item(logic [1:0] act, logic [7:0] b, logic [15:0] tid,
			logic [6:0] fc, logic [15:0] cnt);
		logic [POS_W-1:0] p;
		logic [POS_W-1:0] d;
		logic [3:0]       n;
		logic [8:0]       mask;
		logic             fc_match;
		if (act == ACT_ARM) begin
			armed = 1'b1;
			pos = '0;
			frame_end = '0;
			want_tid = tid;
			want_fc = fc;
			coils_left = cnt;
			hi_byte = '0;
			byte_count = '0;
			got_fc = '0;
			exc_code = '0;
			return;
		end
		if (act == ACT_TIMEOUT) begin
			if (!armed)
				return;
			if (pos == '0)
				close_frame(ST_TIMEOUT, 8'h00);
			else if (pos < POS_FC)
				close_frame(ST_TOO_SHORT, 8'h00);
			else
				close_frame(ST_TRUNCATED, 8'h00);
			return;
		end
		if (act != ACT_BYTE || !armed)
			return;

		p = pos;
		pos = p + 1'b1;
		if (p == POS_TID_HI || p == POS_PROTO_HI || p == POS_LEN_HI) begin
			hi_byte = b;
			return;
		end
		if (p == POS_TID_LO) begin
			if ({hi_byte, b} != want_tid)
				close_frame(ST_TID, 8'h00);
			return;
		end
		if (p == POS_PROTO_LO) begin
			if ({hi_byte, b} != 16'h0000)
				close_frame(ST_PROTOCOL, 8'h00);
			return;
		end
		if (p == POS_LEN_LO) begin
			if ({hi_byte, b} < 16'd2)
				close_frame(ST_LENGTH, 8'h00);
			else
				frame_end = MBAP_BYTES + {hi_byte, b};
			return;
		end

		fc_match = !got_fc[7] && got_fc == {1'b0, want_fc};
		if (p == POS_FC) begin
			got_fc = b;
		end else if (p == POS_COUNT) begin
			if (got_fc[7])
				exc_code = b;
			else
				byte_count = b;
		end else if (p >= POS_DATA && fc_match && (p - POS_DATA) < byte_count) begin
			d = p - POS_DATA;
			if (want_fc == FC_READ_COILS || want_fc == FC_READ_INPUTS) begin
				// lsb first, stop once the requested coils are used up
				if (coils_left != 16'h0000) begin
					n = coils_left < 16'd8 ? coils_left[3:0] : 4'd8;
					mask = (9'd1 << n) - 9'd1;
					push_result(KIND_COIL, {8'h00, b & mask[7:0]}, n, ST_OK, 8'h00);
					coils_left = coils_left - {12'h000, n};
				end
			end else if (want_fc == FC_READ_HOLD || want_fc == FC_READ_INREG) begin
				// big-endian words, a trailing odd byte is dropped
				if (!d[0])
					hi_byte = b;
				else if (d < {byte_count[7:1], 1'b0})
					push_result(KIND_REG, {hi_byte, b}, 4'h0, ST_OK, 8'h00);
			end
		end

		if (p >= POS_FC && pos == frame_end)
			end_of_frame();
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_errors++;
		end
	endfunction

	always @(posedge clk) begin
		parse_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				case (m_tuser)
					KIND_COIL: n_coil++;
					KIND_REG: n_reg++;
					KIND_STATUS: begin
						n_status++;
						seen[m_tdata[23:20]] = 1'b1;
					end
					default: ;
				endcase
				if (parsed_results.size() == 0) begin
					$error("result beat with nothing awaited: kind %0d value %0h status %0d",
						m_tuser, m_tdata[15:0], m_tdata[23:20]);
					n_errors++;
				end else begin
					want = parsed_results.pop_front();
					check_field("result_kind", want.kind, m_tuser);
					check_field("value", want.value, m_tdata[15:0]);
					check_field("bits_valid", want.bits, m_tdata[19:16]);
					check_field("status", want.status, m_tdata[23:20]);
					check_field("exception_code", want.code, m_tdata[31:24]);
					check_field("last", want.last, m_tlast);
				end
			end
			if (s_tvalid && s_tready)
				parse_item(s_tuser, s_tdata[7:0], s_tdata[23:8], s_tdata[30:24], s_tdata[46:31]);
			n_pending <= parsed_results.size();
		end
	end

endmodule

@@ tb/modbus_tcp_response_parser_unit_test.sv @@
`timescale 1ns / 100ps
// top of the modbus tcp response parser testbench: clock, reset, response frames with
// random flaws, bursty input and a stalling output, and the verdict
// depends on mtrp_pkg, modbus_tcp_response_parser_unit, modbus_tcp_response_parser_check
module modbus_tcp_response_parser_unit_test;
	import mtrp_pkg::*;

	// action code the parser ignores
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int ITEM_TARGET = 1850;
	localparam int QUIET_LIMIT = 2000;

	typedef enum int {
		FLAW_NONE,
		FLAW_TID,
		FLAW_PROTOCOL,
		FLAW_LENGTH,
		FLAW_EXCEPTION,
		FLAW_FC,
		FLAW_SHORT,
		FLAW_CUT_LENGTH,
		FLAW_TIMEOUT,
		FLAW_SURPLUS,
		FLAW_REARM,
		FLAW_HUGE,
		FLAW_PADDED
	} flaw_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // data_byte, expected_tid, expected_fc, item_count, zero pad
	logic [1:0]  s_tuser = ACT_ARM;   // action
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;   // value, bits_valid, status, exception_code
	logic [1:0]  m_tuser;   // result_kind
	logic        m_tlast;

	int          errors;
	int          pending;
	int          coil_groups;
	int          reg_words;
	int          statuses;
	logic [15:0] status_seen;

	int items_sent = 0;
	int burst_left = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	modbus_tcp_response_parser_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	modbus_tcp_response_parser_check result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.errors      (errors),
		.pending     (pending),
		.coil_groups (coil_groups),
		.reg_words   (reg_words),
		.statuses    (statuses),
		.status_seen (status_seen)
	);

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// one input beat; bursts of random length with random gaps in between
	task automatic send_item(input logic [1:0] act, input int unsigned b,
			input int unsigned tid, input int unsigned fc, input int unsigned cnt);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
				: $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {1'b0, cnt[15:0], fc[6:0], tid[15:0], b[7:0]};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	// fields other than data_byte are don't-care on a byte beat, so toggle them
	task automatic send_byte(input logic [7:0] b);
		send_item(ACT_BYTE, b, $urandom, $urandom, $urandom);
	endtask

	task automatic run_transaction();
		logic [6:0]  fc;
		logic [15:0] tid;
		logic [15:0] tid_sent;
		logic [15:0] proto;
		logic [15:0] cnt;
		logic [15:0] len;
		logic [7:0]  pdu[$];
		logic [7:0]  frame[$];
		flaw_e       flaw;
		int          pick;
		int          bc;
		int          stop;
		case ($urandom_range(0, 9))
			0, 1, 2: fc = 7'($urandom_range(FC_READ_COILS, FC_READ_INPUTS));
			3, 4, 5: fc = 7'($urandom_range(FC_READ_HOLD, FC_READ_INREG));
			default: fc = 7'($urandom_range(0, 127));
		endcase
		tid = 16'($urandom_range(0, 65535));
		case ($urandom_range(0, 9))
			0: cnt = 16'h0000;
			1: cnt = 16'hFFFF;
			2: cnt = 16'($urandom_range(0, 65535));
			default: cnt = 16'($urandom_range(1, 40));
		endcase
		pick = $urandom_range(0, 19);
		flaw = pick > FLAW_PADDED ? FLAW_NONE : flaw_e'(pick);
		tid_sent = tid;
		proto = 16'h0000;

		pdu.push_back(rand_byte());   // unit id
		if (flaw == FLAW_EXCEPTION) begin
			pdu.push_back({1'b1, fc});
			// sometimes the exception code byte is missing
			if ($urandom_range(0, 1) == 1)
				pdu.push_back(rand_byte());
		end else begin
			if (flaw == FLAW_FC)
				pdu.push_back({1'b0, fc ^ 7'($urandom_range(1, 127))});
			else
				pdu.push_back({1'b0, fc});
			if (fc == FC_READ_COILS || fc == FC_READ_INPUTS) begin
				bc = (int'(cnt) + 7) / 8;
				if (bc > 12)
					bc = 12;
			end else if (fc == FC_READ_HOLD || fc == FC_READ_INREG) begin
				bc = 2 * $urandom_range(0, 6);
			end else begin
				bc = 3;   // write echo: four bytes after the function code
			end
			if ($urandom_range(0, 3) == 0)
				bc = $urandom_range(0, 13);
			pdu.push_back(8'(bc));
			repeat (bc) pdu.push_back(rand_byte());
		end

		len = 16'(pdu.size());
		case (flaw)
			FLAW_TID: tid_sent = tid ^ 16'($urandom_range(1, 65535));
			FLAW_PROTOCOL: proto = 16'($urandom_range(1, 65535));
			FLAW_LENGTH: len = 16'($urandom_range(0, 1));
			FLAW_SHORT: len = 16'd2;
			FLAW_CUT_LENGTH: if (pdu.size() > 2) len = 16'($urandom_range(2, pdu.size() - 1));
			FLAW_HUGE: len = 16'($urandom_range(32768, 65535));
			FLAW_PADDED: begin
				repeat ($urandom_range(1, 3)) pdu.push_back(rand_byte());
				len = 16'(pdu.size());
			end
			default: ;
		endcase

		frame = '{tid_sent[15:8], tid_sent[7:0], proto[15:8], proto[7:0], len[15:8], len[7:0]};
		foreach (pdu[j])
			frame.push_back(pdu[j]);
		stop = frame.size();
		// header errors end the frame early, the rest would only be ignored
		if (flaw == FLAW_TID)
			stop = 2;
		else if (flaw == FLAW_PROTOCOL)
			stop = 4;
		else if (len < 16'd2)
			stop = 6;
		else if (6 + int'(len) < stop)
			stop = 6 + int'(len);
		if (flaw == FLAW_TIMEOUT || flaw == FLAW_REARM)
			stop = $urandom_range(0, stop - 1);

		send_item(ACT_ARM, $urandom, tid, fc, cnt);
		for (int i = 0; i < stop; i++)
			send_byte(frame[i]);
		if (flaw == FLAW_TIMEOUT || flaw == FLAW_HUGE)
			send_item(ACT_TIMEOUT, $urandom, $urandom, $urandom, $urandom);
		if (flaw == FLAW_SURPLUS)
			repeat ($urandom_range(1, 4)) send_byte(rand_byte());
	endtask

	// output side: free-running, random stalls, and now and then a long hold-off
	initial begin : sink
		int seg;
		int n;
		seg = 0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			seg++;
			n = $urandom_range(0, 19);
			if (seg == 6 || n == 0) begin
				// long hold so the queue fills and the input backs up
				m_tready <= 1'b0;
				repeat ($urandom_range(150, 300)) @(posedge clk);
			end else if (n < 8) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(10, 60)) @(posedge clk);
			end else begin
				repeat ($urandom_range(10, 60)) begin
					m_tready <= ($urandom_range(0, 3) != 0);
					@(posedge clk);
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("** modbus_tcp_response_parser_unit: FAILED **");
		$finish;
	end

	initial begin : stimulus
		logic [7:0] exc_frame[8];
		exc_frame = '{8'hA5, 8'hC3, 8'h00, 8'h00, 8'h00, 8'h02, 8'hFF, 8'h83};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle parser: timeout, stray byte and the unused action leave no result
		send_item(ACT_TIMEOUT, 8'h00, 16'hFFFF, 7'h7F, 16'hFFFF);
		send_byte(8'hFF);
		send_item(ACT_UNUSED, 8'hFF, 16'hFFFF, 7'h7F, 16'hFFFF);
		// timeout before any byte
		send_item(ACT_ARM, 8'h00, 16'hFFFF, 7'h7F, 16'hFFFF);
		send_item(ACT_TIMEOUT, 8'hFF, 16'h0000, 7'h00, 16'h0000);
		// timeout inside the header
		send_item(ACT_ARM, 8'hFF, 16'h0000, FC_READ_COILS, 16'd3);
		repeat (3) send_byte(8'h00);
		send_item(ACT_TIMEOUT, 8'h00, 16'h0000, 7'h00, 16'h0000);
		// exception frame of length 2, code byte missing
		send_item(ACT_ARM, 8'h00, 16'hA5C3, FC_READ_HOLD, 16'h0000);
		foreach (exc_frame[i])
			send_byte(exc_frame[i]);

		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 99) < 8)
				send_item(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
			else
				run_transaction();
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("run: %0d input beats; %0d coil groups, %0d register words, %0d final statuses",
			items_sent, coil_groups, reg_words, statuses);
		$display("status codes reached (bit per code): %b", status_seen);
		if (errors == 0 && pending == 0)
			$display("** modbus_tcp_response_parser_unit: PASSED **");
		else
			$display("** modbus_tcp_response_parser_unit: FAILED **");
		$finish;
	end

endmodule
